// ===== sv/pidl_pkg.sv =====
// ============================================================================
// pidl_pkg : shared definitions for the positional insert/delete list
// Operation and status codes, field widths and the command bundle passed
// from the controller to the datapath.
// ============================================================================
package pidl_pkg;

    // Default number of list cells.
    localparam int P_DEPTH = 16;

    // Field widths of the stream items.
    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 40;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // capture the incoming request
        logic exec;  // carry out the held request and fill the result register
    } t_dp_cmd;

endpackage

// ===== sv/pidl_ctrl.sv =====
// ============================================================================
// pidl_ctrl : controller for the positional insert/delete list
// Two-state sequencer that takes one request at a time and owns the
// valid flag of the result register.
// ============================================================================
module pidl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pidl_pkg::t_dp_cmd o_cmd
);
    import pidl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    // The result register can be refilled when empty or being emptied now.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/pidl_datapath.sv =====
// ============================================================================
// pidl_datapath : cell chain and result register of the list
// Holds the request register, the chain of list cells with the entry
// count, and the result register.
// ============================================================================
module pidl_datapath #(
    parameter int DEPTH = pidl_pkg::P_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pidl_pkg::t_dp_cmd           i_cmd,
    input  logic [pidl_pkg::OP_W-1:0]   i_opcode,
    input  logic [pidl_pkg::POS_W-1:0]  i_position,
    input  logic [pidl_pkg::VAL_W-1:0]  i_value,
    output logic [pidl_pkg::STAT_W-1:0] o_status,
    output logic [pidl_pkg::CNT_W-1:0]  o_count,
    output logic [pidl_pkg::VAL_W-1:0]  o_read_value
);
    import pidl_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    // Request register.
    logic [OP_W-1:0]  r_op;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;

    // List cells and entry count.
    logic [VAL_W-1:0] r_cell [DEPTH];
    logic [VAL_W-1:0] n_cell [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    // Result register.
    logic [STAT_W-1:0] r_status;
    logic [CNT_W-1:0]  r_count_out;
    logic [VAL_W-1:0]  r_rd;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [IW-1:0]     rd_idx;
    logic              ins_ok;
    logic              del_ok;
    logic              pos_in_list;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  rd_val;

    assign pos_ext     = CMP_W'(r_pos);
    assign cnt_ext     = CMP_W'(r_count);
    assign rd_idx      = pos_ext[IW-1:0];
    assign pos_in_list = (pos_ext < cnt_ext);
    assign ins_ok      = (r_op == OP_INSERT) && (pos_ext <= cnt_ext)
                         && (cnt_ext < CMP_W'(DEPTH));
    assign del_ok      = (r_op == OP_ERASE) && pos_in_list;

    always_comb begin
        status = ST_RANGE;
        rd_val = '0;
        case (r_op)
            OP_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status = ST_RANGE;
                end else if (!ins_ok) begin
                    status = ST_FULL;
                end else begin
                    status = ST_DONE;
                end
            end
            OP_ERASE: begin
                status = pos_in_list ? ST_DONE : ST_RANGE;
            end
            OP_READ: begin
                if (pos_in_list) begin
                    status = ST_DONE;
                    rd_val = r_cell[rd_idx];
                end
            end
            default: begin
                status = ST_RANGE;
            end
        endcase
    end

    // Every cell looks only at itself and its two neighbours.
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
            if (ins_ok) begin
                if (CMP_W'(i) == pos_ext) begin
                    n_cell[i] = r_val;
                end else if ((CMP_W'(i) > pos_ext) && (i > 0)) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end
            end else if (del_ok) begin
                if ((CMP_W'(i) >= pos_ext) && (i < DEPTH - 1)) begin
                    n_cell[i] = r_cell[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
        if (ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (del_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_cell[i] <= n_cell[i];
            end
            r_status    <= status;
            r_count_out <= CNT_W'(n_count);
            r_rd        <= rd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status     = r_status;
    assign o_count      = r_count_out;
    assign o_read_value = r_rd;

endmodule

// ===== sv/positional_insert_delete_list.sv =====
// ============================================================================
// positional_insert_delete_list : ordered list with positional insert/erase
// Top level joining the stream ports to the controller and the datapath.
// ============================================================================
// The block keeps an ordered list of up to DEPTH signed 32-bit values in a
// chain of register cells. Each request is an insert, an erase or a read at a
// zero-based position; insert and erase move every later cell by one place
// together, so the cost of a request does not depend on the position or on
// how full the list is. Each request is first captured and then executed: in
// the execute step the cell chain updates and the result register is filled,
// and only after that is the next request taken. The result waits in its own
// register, so a new request is captured while the previous result is still
// held; the execute cycle waits only while that register is full and not being
// read. Every request gives exactly one result: a status (done, position out
// of range, or list full on insert), the count after the operation and the
// read value, which is zero unless a read succeeded. Rejected requests leave
// the list untouched, and a bad position is reported ahead of a full list.
// Cells above the count hold stale data and are never returned.
module positional_insert_delete_list #(
    parameter int DEPTH = pidl_pkg::P_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request stream.
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [1:0] opcode, [6:2] position, [38:7] value, [39] zero
    input  logic [pidl_pkg::IN_DW-1:0]  i_s_axis_tdata,
    // Result stream.
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [1:0] status, [6:2] count, [38:7] read_value, [39] zero
    output logic [pidl_pkg::OUT_DW-1:0] o_m_axis_tdata
);
    import pidl_pkg::*;

    t_dp_cmd           cmd;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic [VAL_W-1:0]  read_value;

    pidl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    pidl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_s_axis_tdata[1:0]),
        .i_position   (i_s_axis_tdata[6:2]),
        .i_value      (i_s_axis_tdata[38:7]),
        .o_status     (status),
        .o_count      (count),
        .o_read_value (read_value)
    );

    assign o_m_axis_tdata = {1'b0, read_value, count, status};

    // Only one request is in flight: an accepted request closes the input.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while another is being executed");

    // With the result register free, the result comes with no execute stall.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready
         && (!o_m_axis_tvalid || i_m_axis_tready)) |=> ##1 o_m_axis_tvalid)
        else $error("result did not appear after execution");

    // A fresh result is only produced from the execute cycle.
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result raised without a request in execution");

endmodule
